[design/pim_pkg.sv]
// ----------------------------------------------------------------------------
// pim_pkg: shared types and constants for the priority inheritance mutex
// Widths, wait list depth, status codes, controller states and the cell
// payload type used by the wait list and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package pim_pkg;

  localparam int TID_W      = 5;
  localparam int PRIO_W     = 8;
  localparam int HOLD_W     = 16;
  localparam int WAIT_DEPTH = 16;
  localparam int CNT_W      = $clog2(WAIT_DEPTH + 1);

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 48;

  localparam logic [HOLD_W-1:0] HOLD_LIMIT = 16'hFFFF;
  localparam logic [PRIO_W-1:0] PRIO_IDLE  = 8'hFF;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BUSY       = 3'd1,
    ST_QUEUED     = 3'd2,
    ST_NOT_OWNER  = 3'd3,
    ST_LIST_FULL  = 3'd4,
    ST_COUNT_FULL = 3'd5
  } status_t;

  typedef enum logic {
    OP_LOCK   = 1'b0,
    OP_UNLOCK = 1'b1
  } op_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] prio;
  } waiter_t;

  typedef struct packed {
    logic insert;
    logic pop;
  } list_ctrl_t;

endpackage

`default_nettype wire

[design/pim_cell.sv]
// ----------------------------------------------------------------------------
// pim_cell: one slot of the sorted wait list
// Holds one waiter. On insert it keeps its entry, takes the new waiter or
// takes its lower neighbor's entry; on pop it takes its upper neighbor's.
// ----------------------------------------------------------------------------
`default_nettype none

module pim_cell
  import pim_pkg::*;
(
  input  wire logic       clk,
  input  wire list_ctrl_t ctrl,
  input  wire waiter_t    new_item,
  input  wire logic       occupied,
  input  wire logic       prev_keep,
  input  wire waiter_t    prev_item,
  input  wire waiter_t    next_item,
  output logic            keep,
  output waiter_t         item
);

  waiter_t item_r;
  waiter_t item_nxt;

  // Entry stays in place when it is at least as urgent as the newcomer,
  // which keeps FIFO order among equal priorities.
  assign keep = occupied && (item_r.prio <= new_item.prio);
  assign item = item_r;

  always_comb begin
    item_nxt = item_r;
    if (ctrl.insert) begin
      if (keep) begin
        item_nxt = item_r;
      end else if (prev_keep) begin
        item_nxt = new_item;
      end else begin
        item_nxt = prev_item;
      end
    end else if (ctrl.pop) begin
      item_nxt = next_item;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

`default_nettype wire

[design/pim_wait_list.sv]
// ----------------------------------------------------------------------------
// pim_waiter_row: priority-sorted wait list as a row of cells
// Cell 0 is the head. The fill count marks which cells hold waiters.
// ----------------------------------------------------------------------------
`default_nettype none

module pim_waiter_row
  import pim_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire list_ctrl_t ctrl,
  input  wire waiter_t    new_item,
  output waiter_t         head,
  output logic [CNT_W-1:0] count
);

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  waiter_t          cell_item [WAIT_DEPTH];
  logic             cell_keep [WAIT_DEPTH];

  genvar i;
  generate
    for (i = 0; i < WAIT_DEPTH; i++) begin : g_cell
      localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
      logic    prev_keep;
      waiter_t prev_item;
      waiter_t next_item;

      if (i == 0) begin : g_first
        assign prev_keep = 1'b1;
        assign prev_item = new_item;
      end else begin : g_mid
        assign prev_keep = cell_keep[i-1];
        assign prev_item = cell_item[i-1];
      end

      if (i == WAIT_DEPTH - 1) begin : g_last
        assign next_item = cell_item[i];
      end else begin : g_up
        assign next_item = cell_item[i+1];
      end

      pim_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .new_item  (new_item),
        .occupied  (IDX < count_r),
        .prev_keep (prev_keep),
        .prev_item (prev_item),
        .next_item (next_item),
        .keep      (cell_keep[i]),
        .item      (cell_item[i])
      );
    end
  endgenerate

  always_comb begin
    count_nxt = count_r;
    if (ctrl.insert) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign head  = cell_item[0];
  assign count = count_r;

endmodule

`default_nettype wire

[design/priority_inheritance_mutex_top.sv]
// ----------------------------------------------------------------------------
// priority_inheritance_mutex_top: recursive mutex with priority inheritance
// Serves lock and unlock requests, tracks owner, hold count and priorities,
// and keeps a priority-sorted wait list in a row of shift cells.
// ----------------------------------------------------------------------------
//
//  channel | dir | width | contents
//  --------+-----+-------+---------------------------------------------------
//  in_     | in  |  16   | one lock or unlock request per transfer
//  out_    | out |  48   | one result per request, in request order
//
//  Flow: the request is first captured into the request registers; in the
//  execute state it is then decided, which updates the owner registers, shifts
//  the wait list cells by one (insert or pop) and loads the output register.
//  Reset: rst_n low for one clock frees the mutex and empties the wait list.
//  Stalls: a request is taken while an earlier result still waits in the
//  output register; its decision is held off until that result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_inheritance_mutex_top
  import pim_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [0] operation, [5:1] thread_id, [13:6] thread_priority,
  // [14] wait_allowed, [15] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [2:0] status, [3] boost_valid, [8:4] boost_thread,
  // [16:9] boost_priority, [17] restore_valid, [25:18] restore_priority,
  // [26] handover_valid, [31:27] handover_thread, [47:32] hold_count_now
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  // controller
  state_t state_r;
  state_t state_nxt;

  // captured request
  op_t               op_r;
  logic [TID_W-1:0]  tid_r;
  logic [PRIO_W-1:0] prio_r;
  logic              wait_r;

  // owner state
  logic              owner_valid_r, owner_valid_nxt;
  logic [TID_W-1:0]  owner_tid_r,   owner_tid_nxt;
  logic [PRIO_W-1:0] eff_prio_r,    eff_prio_nxt;
  logic [PRIO_W-1:0] orig_prio_r,   orig_prio_nxt;
  logic [HOLD_W-1:0] hold_r,        hold_nxt;

  // result register
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r,  out_data_nxt;

  // wait list
  list_ctrl_t       list_ctrl;
  waiter_t          new_waiter;
  waiter_t          head;
  logic [CNT_W-1:0] wait_count;

  logic              in_xfer;
  logic              exec;
  status_t           status;
  logic              bv, rv, hv;
  logic [TID_W-1:0]  bt, ht;
  logic [PRIO_W-1:0] bp, rp;
  logic              do_insert, do_pop;

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  // decide only when the result register is free or being emptied
  assign exec      = (state_r == S_EXEC) && (!out_valid_r || out_tready);

  assign new_waiter.tid  = tid_r;
  assign new_waiter.prio = prio_r;
  assign list_ctrl.insert = exec && do_insert;
  assign list_ctrl.pop    = exec && do_pop;

  pim_waiter_row u_waiters (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (list_ctrl),
    .new_item (new_waiter),
    .head     (head),
    .count    (wait_count)
  );

  // request decision
  always_comb begin
    status          = ST_OK;
    bv = 1'b0; bt = '0; bp = '0;
    rv = 1'b0; rp = '0;
    hv = 1'b0; ht = '0;
    do_insert       = 1'b0;
    do_pop          = 1'b0;
    owner_valid_nxt = owner_valid_r;
    owner_tid_nxt   = owner_tid_r;
    eff_prio_nxt    = eff_prio_r;
    orig_prio_nxt   = orig_prio_r;
    hold_nxt        = hold_r;

    if (op_r == OP_LOCK) begin
      if (owner_valid_r && (owner_tid_r == tid_r)) begin
        if (hold_r >= HOLD_LIMIT) begin
          status = ST_COUNT_FULL;
        end else begin
          hold_nxt = hold_r + HOLD_W'(1);
        end
      end else if (!owner_valid_r) begin
        owner_valid_nxt = 1'b1;
        owner_tid_nxt   = tid_r;
        hold_nxt        = HOLD_W'(1);
        orig_prio_nxt   = prio_r;
        eff_prio_nxt    = prio_r;
      end else if (!wait_r) begin
        status = ST_BUSY;
      end else if (wait_count >= CNT_W'(WAIT_DEPTH)) begin
        status = ST_LIST_FULL;
      end else begin
        // caller more urgent than owner: owner inherits its priority
        if (prio_r < eff_prio_r) begin
          eff_prio_nxt = prio_r;
          bv = 1'b1;
          bt = owner_tid_r;
          bp = prio_r;
        end
        do_insert = 1'b1;
        status    = ST_QUEUED;
      end
    end else begin
      if (!owner_valid_r || (owner_tid_r != tid_r) || (hold_r == '0)) begin
        status = ST_NOT_OWNER;
      end else if (hold_r == HOLD_W'(1)) begin
        // final unlock
        if (eff_prio_r != orig_prio_r) begin
          rv = 1'b1;
          rp = orig_prio_r;
        end
        if (wait_count != '0) begin
          owner_tid_nxt = head.tid;
          orig_prio_nxt = head.prio;
          eff_prio_nxt  = head.prio;
          hold_nxt      = HOLD_W'(1);
          hv            = 1'b1;
          ht            = head.tid;
          do_pop        = 1'b1;
        end else begin
          owner_valid_nxt = 1'b0;
          owner_tid_nxt   = '0;
          orig_prio_nxt   = PRIO_IDLE;
          eff_prio_nxt    = PRIO_IDLE;
          hold_nxt        = '0;
        end
      end else begin
        hold_nxt = hold_r - HOLD_W'(1);
      end
    end
  end

  // controller next state and result register
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (exec) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt  = {hold_nxt, ht, hv, rp, rv, bp, bt, bv, status};
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      owner_valid_r <= 1'b0;
      owner_tid_r   <= '0;
      eff_prio_r    <= PRIO_IDLE;
      orig_prio_r   <= PRIO_IDLE;
      hold_r        <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (exec) begin
        owner_valid_r <= owner_valid_nxt;
        owner_tid_r   <= owner_tid_nxt;
        eff_prio_r    <= eff_prio_nxt;
        orig_prio_r   <= orig_prio_nxt;
        hold_r        <= hold_nxt;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (in_xfer) begin
      op_r   <= op_t'(in_tdata[0]);
      tid_r  <= in_tdata[5:1];
      prio_r <= in_tdata[13:6];
      wait_r <= in_tdata[14];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    wait_count <= CNT_W'(WAIT_DEPTH))
    else $error("wait list count beyond depth");

  a_free_no_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !owner_valid_r |-> (hold_r == '0) && (wait_count == '0))
    else $error("free mutex with hold count or waiters");

  a_owner_holds : assert property (@(posedge clk) disable iff (!rst_n)
    owner_valid_r |-> (hold_r != '0))
    else $error("owned mutex with zero hold count");

  a_eff_le_orig : assert property (@(posedge clk) disable iff (!rst_n)
    eff_prio_r <= orig_prio_r)
    else $error("effective priority less urgent than original");

  a_one_result : assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_EXEC) && !in_tready)
    else $error("request accepted without entering execute");
`endif

endmodule

`default_nettype wire

[sim/pim_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pim_checker: result checker for the priority inheritance mutex
// Mirrors the mutex from the accepted requests and checks every result
// transfer against the oldest expected result.
// ----------------------------------------------------------------------------
module pim_checker
  import pim_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  output int                    mismatch_count,
  output int                    pending_results
);

  // same bit layout as out_tdata, highest field first
  typedef struct packed {
    logic [HOLD_W-1:0] hold_now;
    logic [TID_W-1:0]  handover_tid;
    logic              handover_v;
    logic [PRIO_W-1:0] restore_prio;
    logic              restore_v;
    logic [PRIO_W-1:0] boost_prio;
    logic [TID_W-1:0]  boost_tid;
    logic              boost_v;
    status_t           status;
  } mutex_result_t;

  logic              own_valid;
  logic [TID_W-1:0]  own_tid;
  logic [PRIO_W-1:0] own_eff;
  logic [PRIO_W-1:0] own_orig;
  logic [HOLD_W-1:0] hold_cnt;
  waiter_t           mirror_q [WAIT_DEPTH];
  int                wait_len;

  mutex_result_t expected_results [$];
  mutex_result_t want;
  mutex_result_t got;

  initial begin
    mismatch_count  = 0;
    pending_results = 0;
  end

  // apply one request to the mirrored mutex and form its result
  task automatic decide_request(input logic [IN_DATA_W-1:0] req,
                                output mutex_result_t res);
    op_t               op;
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] prio;
    logic              may_wait;
    int                pos;
    op       = op_t'(req[0]);
    tid      = req[5:1];
    prio     = req[13:6];
    may_wait = req[14];
    res        = '0;
    res.status = ST_OK;
    if (op == OP_LOCK) begin
      if (own_valid && own_tid == tid) begin
        if (hold_cnt == HOLD_LIMIT) res.status = ST_COUNT_FULL;
        else hold_cnt = hold_cnt + 1'b1;
      end else if (!own_valid) begin
        own_valid = 1'b1;
        own_tid   = tid;
        hold_cnt  = 1;
        own_orig  = prio;
        own_eff   = prio;
      end else if (!may_wait) begin
        res.status = ST_BUSY;
      end else if (wait_len >= WAIT_DEPTH) begin
        res.status = ST_LIST_FULL;
      end else begin
        if (prio < own_eff) begin
          own_eff        = prio;
          res.boost_v    = 1'b1;
          res.boost_tid  = own_tid;
          res.boost_prio = prio;
        end
        // sorted insert, behind all entries of equal or better priority
        pos = 0;
        while (pos < wait_len && mirror_q[pos].prio <= prio) pos++;
        for (int k = wait_len; k > pos; k--) mirror_q[k] = mirror_q[k-1];
        mirror_q[pos].tid  = tid;
        mirror_q[pos].prio = prio;
        wait_len++;
        res.status = ST_QUEUED;
      end
    end else begin
      if (!own_valid || own_tid != tid || hold_cnt == 0) begin
        res.status = ST_NOT_OWNER;
      end else begin
        hold_cnt = hold_cnt - 1'b1;
        if (hold_cnt == 0) begin
          if (own_eff != own_orig) begin
            res.restore_v    = 1'b1;
            res.restore_prio = own_orig;
          end
          if (wait_len > 0) begin
            own_tid          = mirror_q[0].tid;
            own_orig         = mirror_q[0].prio;
            own_eff          = mirror_q[0].prio;
            hold_cnt         = 1;
            res.handover_v   = 1'b1;
            res.handover_tid = own_tid;
            for (int k = 1; k < wait_len; k++) mirror_q[k-1] = mirror_q[k];
            wait_len--;
          end else begin
            own_valid = 1'b0;
            own_tid   = '0;
            own_orig  = PRIO_IDLE;
            own_eff   = PRIO_IDLE;
          end
        end
      end
    end
    res.hold_now = hold_cnt;
  endtask

  function automatic string show(input mutex_result_t r);
    return $sformatf("status=%0d boost=%0b/%0d/%0d restore=%0b/%0d handover=%0b/%0d hold=%0d",
                     r.status, r.boost_v, r.boost_tid, r.boost_prio, r.restore_v,
                     r.restore_prio, r.handover_v, r.handover_tid, r.hold_now);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      own_valid = 1'b0;
      own_tid   = '0;
      own_eff   = PRIO_IDLE;
      own_orig  = PRIO_IDLE;
      hold_cnt  = '0;
      wait_len  = 0;
      expected_results.delete();
    end else begin
      // results first: a request taken at this edge cannot answer at it
      if (out_tvalid && out_tready) begin
        got = mutex_result_t'(out_tdata);
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("%t: result with no request outstanding: %s", $time, show(got));
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status || got.boost_v != want.boost_v ||
              got.boost_tid != want.boost_tid || got.boost_prio != want.boost_prio ||
              got.restore_v != want.restore_v || got.restore_prio != want.restore_prio ||
              got.handover_v != want.handover_v ||
              got.handover_tid != want.handover_tid || got.hold_now != want.hold_now) begin
            if (mismatch_count < 10) begin
              $display("%t: mismatch", $time);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
            mismatch_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        decide_request(in_tdata, want);
        expected_results.push_back(want);
      end
    end
    pending_results = expected_results.size();
  end

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench top for the priority inheritance mutex
// Drives lock and unlock requests (directed cases, a wait list fill and
// overflow run, then random sessions over small thread pools) with random
// gaps and output stalls; pim_checker predicts and checks every result.
// ----------------------------------------------------------------------------
module tb;
  import pim_pkg::*;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  // idling on both sides is allowed only while this is set
  logic stall_enable = 1'b0;
  int   stall_left   = 0;

  int mismatch_count;
  int pending_results;

  priority_inheritance_mutex_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  pim_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Hard stop, well beyond the time that about 700 transfers take under the
  // longest gaps and stalls.
  initial begin
    #4_000_000;
    $display("tb failed");
    $finish;
  end

  // Result side back-pressure: random bursts of stalls while stall_enable is set.
  always @(posedge clk) begin
    if (!stall_enable) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 11);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // One request transfer. Called at a rising edge; returns at the edge that
  // took the request, with valid still high so back-to-back items need no
  // second assignment in the same step.
  task automatic send_req(input op_t op, input logic [TID_W-1:0] tid,
                          input logic [PRIO_W-1:0] prio, input logic may_wait);
    int gap;
    if (stall_enable && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 12);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    // [0] op, [5:1] thread, [13:6] priority, [14] may wait, [15] zero
    in_tdata  <= {1'b0, may_wait, prio, tid, op};
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    logic [TID_W-1:0]  pool [4];
    logic [PRIO_W-1:0] prio_set [4];
    logic [TID_W-1:0]  tid;
    logic [PRIO_W-1:0] prio;
    op_t               op;
    int                pick;
    int                wait_cycles;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: non-full statuses, boost, restore, handover, FIFO ties ---
    stall_enable <= 1'b1;
    send_req(OP_UNLOCK, 5'd3, 8'd9, 1'b1);     // unlock of a free mutex
    send_req(OP_LOCK, 5'd0, 8'd255, 1'b0);     // grant, lowest urgency
    send_req(OP_LOCK, 5'd0, 8'd17, 1'b0);      // recursive, count 2
    send_req(OP_LOCK, 5'd31, 8'd0, 1'b0);      // busy, caller will not wait
    send_req(OP_UNLOCK, 5'd31, 8'd0, 1'b0);    // unlock by a non-owner
    send_req(OP_LOCK, 5'd31, 8'd0, 1'b1);      // queued, owner boosted to 0
    send_req(OP_LOCK, 5'd5, 8'd0, 1'b1);       // equal priority, behind 31
    send_req(OP_LOCK, 5'd31, 8'd200, 1'b1);    // same thread queued twice
    send_req(OP_UNLOCK, 5'd0, 8'd0, 1'b0);     // count back to 1
    send_req(OP_UNLOCK, 5'd0, 8'd0, 1'b0);     // restore 255, hand to 31
    send_req(OP_UNLOCK, 5'd31, 8'd0, 1'b0);    // no restore, hand to 5
    send_req(OP_UNLOCK, 5'd5, 8'd0, 1'b0);     // hand to 31 again (prio 200)
    send_req(OP_UNLOCK, 5'd31, 8'd0, 1'b0);    // mutex free again

    // --- wait list fill and overflow; no idling here ---
    stall_enable <= 1'b0;
    send_req(OP_LOCK, 5'd7, 8'd128, 1'b0);     // grant
    send_req(OP_LOCK, 5'd7, 8'd128, 1'b0);     // recursive, count 2
    // falling priorities: each waiter lands at the head and boosts the owner
    for (int k = 0; k < WAIT_DEPTH; k++)
      send_req(OP_LOCK, TID_W'(8 + k), PRIO_W'(WAIT_DEPTH - k), 1'b1);
    send_req(OP_LOCK, 5'd24, 8'd0, 1'b1);      // list full, no boost
    send_req(OP_LOCK, 5'd25, 8'd0, 1'b0);      // busy takes priority over full
    send_req(OP_UNLOCK, 5'd7, 8'd0, 1'b0);     // count back to 1
    send_req(OP_UNLOCK, 5'd7, 8'd0, 1'b0);     // restore 128, hand to the head
    // drain in list order, the last unlock frees the mutex
    for (int k = WAIT_DEPTH - 1; k >= 0; k--)
      send_req(OP_UNLOCK, TID_W'(8 + k), 8'd0, 1'b0);

    // --- random sessions over small thread pools ---
    // A small pool keeps unlocks landing on the owner often enough to see
    // handovers; a few priorities per session make ties in the wait list.
    for (int seg = 0; seg < 13; seg++) begin
      for (int k = 0; k < 4; k++) begin
        pool[k]     = TID_W'($urandom_range(0, 31));
        prio_set[k] = PRIO_W'($urandom_range(0, 255));
      end
      // the last two sessions run with no idling
      stall_enable <= (seg < 11) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 50; n++) begin
        op  = ($urandom_range(0, 9) < 4) ? OP_UNLOCK : OP_LOCK;
        tid = ($urandom_range(0, 9) == 0) ? TID_W'($urandom_range(0, 31))
                                          : pool[$urandom_range(0, 3)];
        pick = $urandom_range(0, 9);
        if (pick < 7)       prio = prio_set[$urandom_range(0, 3)];
        else if (pick == 7) prio = 8'd0;
        else if (pick == 8) prio = 8'd255;
        else                prio = PRIO_W'($urandom_range(0, 255));
        send_req(op, tid, prio, $urandom_range(0, 7) != 0);
      end
    end
    in_tvalid <= 1'b0;

    // drain, then a short tail for any stray result
    wait_cycles = 0;
    while (pending_results != 0 && wait_cycles < 5000) begin
      @(negedge clk);
      wait_cycles++;
    end
    repeat (10) @(negedge clk);

    if (mismatch_count == 0 && pending_results == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

[files.f]
design/pim_pkg.sv
design/pim_cell.sv
design/pim_wait_list.sv
design/priority_inheritance_mutex_top.sv
sim/pim_checker.sv
sim/tb.sv
